FILE: src/ffsa_pkg.sv
package ffsa_pkg;

    // operation codes carried in the op field
    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_LOOKUP   = 2'd2;
    localparam logic [1:0] OP_FREE_ALL = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // which fields a result takes
    typedef enum logic [1:0] {
        RES_NONE        = 2'd0,
        RES_HIT_ADDR    = 2'd1,
        RES_HIT_ID_ADDR = 2'd2,
        RES_APPEND      = 2'd3
    } res_kind_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic      load;
        logic      scan;
        logic      shift_start;
        logic      shift;
        logic      wr_rem;
        logic      wr_take;
        logic      wr_append;
        logic      compact_start;
        logic      compact;
        logic      flush;
        logic      res_set;
        logic [1:0] res_status;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       need_zero;
        logic       scan_done;
        logic       hit;
        logic       owner_ok;
        logic       split_ok;
        logic       append_fail;
        logic       shift_done;
        logic       compact_done;
        logic       out_free;
    } sts_t;

endpackage

FILE: src/ffsa_dpath.sv
module ffsa_dpath #(
    parameter int MAX_SEGMENTS = 64,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  ffsa_pkg::cmd_t cmd,
    output ffsa_pkg::sts_t sts,
    input  logic [1:0]     in_op,
    input  logic [31:0]    in_size,
    input  logic [31:0]    in_id,
    input  logic [15:0]    in_req,
    input  logic           cfg_we,
    input  logic [19:0]    cfg_base,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [1:0]     out_status,
    output logic [31:0]    out_id,
    output logic [31:0]    out_addr
);

    localparam int SH     = $clog2(PAGE_BYTES);
    localparam int NEED_W = 33 - SH;
    localparam int PG_W   = (NEED_W > 21) ? NEED_W : 21;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam logic [PG_W:0]  END_PAGE = {{PG_W{1'b0}}, 1'b1} << (32 - SH);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

    typedef struct packed {
        logic [31:0]     id;
        logic [PG_W-1:0] start;
        logic [PG_W-1:0] pages;
        logic            used;
        logic [15:0]     owner;
    } ent_t;

    ent_t mem_reg [MAX_SEGMENTS];
    ent_t rdata_reg;

    logic             we;
    logic [IDX_W-1:0] waddr;
    ent_t             wdata;
    logic [IDX_W-1:0] raddr;

    logic [1:0]        op_reg, op_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [31:0]       id_reg, id_next;
    logic [15:0]       req_reg, req_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       next_id_reg, next_id_next;
    logic [PG_W-1:0]   tail_reg, tail_next;
    logic [19:0]       base_reg, base_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rvalid_reg, rvalid_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    ent_t              hit_ent_reg, hit_ent_next;
    ent_t              pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              trim_reg, trim_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [31:0]       res_id_reg, res_id_next;
    logic [31:0]       res_addr_reg, res_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [31:0]       out_id_reg, out_id_next;
    logic [31:0]       out_addr_reg, out_addr_next;

    logic [PG_W-1:0]    need_ext;
    logic [NEED_W-1:0]  in_need;
    logic               match;
    ent_t               cur;
    logic [PG_W+SH-1:0] hit_byte;
    logic [PG_W+SH-1:0] tail_byte;

    // page count rounded up from the byte size
    assign in_need  = {1'b0, in_size[31:SH]} + NEED_W'(|in_size[SH-1:0]);
    assign need_ext = PG_W'(need_reg);
    assign hit_byte  = {hit_ent_reg.start, {SH{1'b0}}};
    assign tail_byte = {tail_reg, {SH{1'b0}}};

    // scan match and free marking on the entry just read
    always_comb begin
        cur = rdata_reg;
        if (op_reg == ffsa_pkg::OP_ALLOC) begin
            match = !rdata_reg.used && (rdata_reg.pages >= need_ext);
        end else begin
            match = rdata_reg.used && (rdata_reg.id == id_reg);
        end
        if ((op_reg == ffsa_pkg::OP_FREE_ALL && rdata_reg.used && rdata_reg.owner == req_reg)
            || (op_reg == ffsa_pkg::OP_FREE && rd_idx_reg == hit_idx_reg)) begin
            cur.used = 1'b0;
        end
    end

    // segment table
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    // next state of the datapath
    always_comb begin
        op_next         = op_reg;
        need_next       = need_reg;
        id_next         = id_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        tail_next       = tail_reg;
        base_next       = base_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_idx_next     = rd_idx_reg;
        rvalid_next     = rvalid_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_ent_next    = hit_ent_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        trim_next       = trim_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_addr_next   = out_addr_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = rdata_reg;
        raddr           = rd_ptr_reg[IDX_W-1:0];

        // base register write; the tail follows it while the table is empty
        if (cfg_we) begin
            base_next = cfg_base;
            if (count_reg == '0) begin
                tail_next = PG_W'(cfg_base);
            end
        end

        // capture request and clear walk state
        if (cmd.load) begin
            op_next         = in_op;
            need_next       = in_need;
            id_next         = in_id;
            req_next        = in_req;
            rd_ptr_next     = '0;
            wr_ptr_next     = '0;
            rvalid_next     = 1'b0;
            hit_next        = 1'b0;
            pend_valid_next = 1'b0;
            trim_next       = 1'b0;
        end

        // forward scan for the first match
        if (cmd.scan) begin
            rvalid_next = 1'b0;
            if (!hit_reg && rd_ptr_reg < count_reg) begin
                rvalid_next = 1'b1;
                rd_idx_next = rd_ptr_reg[IDX_W-1:0];
                rd_ptr_next = rd_ptr_reg + CNT_W'(1);
            end
            if (rvalid_reg && !hit_reg && match) begin
                hit_next     = 1'b1;
                hit_idx_next = rd_idx_reg;
                hit_ent_next = rdata_reg;
            end
        end

        // move entries above the hit up by one, top first
        if (cmd.shift_start) begin
            rd_ptr_next = count_reg - CNT_W'(1);
            rvalid_next = 1'b0;
        end
        if (cmd.shift) begin
            rvalid_next = 1'b0;
            if (rd_ptr_reg > CNT_W'(hit_idx_reg)) begin
                rvalid_next = 1'b1;
                rd_idx_next = rd_ptr_reg[IDX_W-1:0];
                rd_ptr_next = rd_ptr_reg - CNT_W'(1);
            end
            if (rvalid_reg) begin
                we    = 1'b1;
                waddr = rd_idx_reg + IDX_W'(1);
                wdata = rdata_reg;
            end
        end

        // free remainder after the split
        if (cmd.wr_rem) begin
            we          = 1'b1;
            waddr       = hit_idx_reg + IDX_W'(1);
            wdata.id    = next_id_reg;
            wdata.start = hit_ent_reg.start + need_ext;
            wdata.pages = hit_ent_reg.pages - need_ext;
            wdata.used  = 1'b0;
            wdata.owner = '0;
            next_id_next = next_id_reg + 32'd1;
            count_next   = count_reg + CNT_W'(1);
            trim_next    = 1'b1;
        end

        // reused segment becomes used
        if (cmd.wr_take) begin
            we          = 1'b1;
            waddr       = hit_idx_reg;
            wdata       = hit_ent_reg;
            wdata.used  = 1'b1;
            wdata.owner = req_reg;
            if (trim_reg) begin
                wdata.pages = need_ext;
            end
        end

        // new segment at the tail
        if (cmd.wr_append) begin
            we           = 1'b1;
            waddr        = count_reg[IDX_W-1:0];
            wdata.id     = next_id_reg;
            wdata.start  = tail_reg;
            wdata.pages  = need_ext;
            wdata.used   = 1'b1;
            wdata.owner  = req_reg;
            next_id_next = next_id_reg + 32'd1;
            count_next   = count_reg + CNT_W'(1);
            tail_next    = tail_reg + need_ext;
        end

        // compaction: mark freed entries and merge free runs
        if (cmd.compact_start) begin
            rd_ptr_next     = '0;
            wr_ptr_next     = '0;
            rvalid_next     = 1'b0;
            pend_valid_next = 1'b0;
        end
        if (cmd.compact) begin
            rvalid_next = 1'b0;
            if (rd_ptr_reg < count_reg) begin
                rvalid_next = 1'b1;
                rd_idx_next = rd_ptr_reg[IDX_W-1:0];
                rd_ptr_next = rd_ptr_reg + CNT_W'(1);
            end
            if (rvalid_reg) begin
                if (pend_valid_reg && !pend_reg.used && !cur.used) begin
                    pend_next.pages = pend_reg.pages + cur.pages;
                end else begin
                    if (pend_valid_reg) begin
                        we          = 1'b1;
                        waddr       = wr_ptr_reg[IDX_W-1:0];
                        wdata       = pend_reg;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                    pend_next       = cur;
                    pend_valid_next = 1'b1;
                end
            end
        end
        if (cmd.flush) begin
            if (pend_valid_reg) begin
                we    = 1'b1;
                waddr = wr_ptr_reg[IDX_W-1:0];
                wdata = pend_reg;
            end
            count_next = wr_ptr_reg + CNT_W'(pend_valid_reg);
        end

        // staged result
        if (cmd.res_set) begin
            res_status_next = cmd.res_status;
            res_id_next     = '0;
            res_addr_next   = '0;
            case (cmd.res_kind)
                ffsa_pkg::RES_HIT_ADDR: begin
                    res_addr_next = hit_byte[31:0];
                end
                ffsa_pkg::RES_HIT_ID_ADDR: begin
                    res_id_next   = hit_ent_reg.id;
                    res_addr_next = hit_byte[31:0];
                end
                ffsa_pkg::RES_APPEND: begin
                    res_id_next   = next_id_reg;
                    res_addr_next = tail_byte[31:0];
                end
                default: begin
                    res_id_next = '0;
                end
            endcase
        end

        // output register
        if (cmd.out_load) begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_id_next     = res_id_reg;
            out_addr_next   = res_addr_reg;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            next_id_reg    <= '0;
            tail_reg       <= PG_W'(20'd131072);
            base_reg       <= 20'd131072;
            rvalid_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            trim_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
        end else begin
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            tail_reg       <= tail_next;
            base_reg       <= base_next;
            rvalid_reg     <= rvalid_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            trim_reg       <= trim_next;
            out_valid_reg  <= out_valid_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        need_reg       <= need_next;
        id_reg         <= id_next;
        req_reg        <= req_next;
        rd_idx_reg     <= rd_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_ent_reg    <= hit_ent_next;
        pend_reg       <= pend_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_addr_reg   <= out_addr_next;
    end

    // status to the controller
    always_comb begin
        sts.op           = op_reg;
        sts.need_zero    = (need_reg == '0);
        sts.scan_done    = hit_reg || (rd_ptr_reg >= count_reg && !rvalid_reg);
        sts.hit          = hit_reg;
        sts.owner_ok     = (hit_ent_reg.owner == req_reg);
        sts.split_ok     = (hit_ent_reg.pages > need_ext) && (count_reg < MAX_CNT);
        sts.append_fail  = (count_reg >= MAX_CNT)
                           || (({1'b0, tail_reg} + {1'b0, need_ext}) > END_PAGE);
        sts.shift_done   = !(rd_ptr_reg > CNT_W'(hit_idx_reg)) && !rvalid_reg;
        sts.compact_done = (rd_ptr_reg >= count_reg) && !rvalid_reg;
        sts.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;
    assign out_addr   = out_addr_reg;

endmodule

FILE: src/ffsa_ctrl.sv
module ffsa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ffsa_pkg::sts_t sts,
    output ffsa_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_SHIFT   = 9'b000000100,
        S_REM     = 9'b000001000,
        S_TAKE    = 9'b000010000,
        S_APPEND  = 9'b000100000,
        S_COMPACT = 9'b001000000,
        S_FLUSH   = 9'b010000000,
        S_RESP    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // sequencing of the request phases
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_kind   = ffsa_pkg::RES_NONE;
        cmd.res_status = ffsa_pkg::ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.op == ffsa_pkg::OP_FREE_ALL) begin
                    state_next = S_COMPACT;
                end else if (sts.op == ffsa_pkg::OP_ALLOC && sts.need_zero) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ffsa_pkg::ST_NOSPACE;
                    state_next     = S_RESP;
                end else if (!sts.scan_done) begin
                    cmd.scan = 1'b1;
                end else begin
                    case (sts.op)
                        ffsa_pkg::OP_LOOKUP: begin
                            cmd.res_set = 1'b1;
                            if (sts.hit) begin
                                cmd.res_kind = ffsa_pkg::RES_HIT_ADDR;
                            end else begin
                                cmd.res_status = ffsa_pkg::ST_NOTFOUND;
                            end
                            state_next = S_RESP;
                        end
                        ffsa_pkg::OP_FREE: begin
                            if (sts.hit && sts.owner_ok) begin
                                cmd.compact_start = 1'b1;
                                state_next        = S_COMPACT;
                            end else begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = ffsa_pkg::ST_NOTFOUND;
                                state_next     = S_RESP;
                            end
                        end
                        default: begin
                            if (sts.hit) begin
                                if (sts.split_ok) begin
                                    cmd.shift_start = 1'b1;
                                    state_next      = S_SHIFT;
                                end else begin
                                    state_next = S_TAKE;
                                end
                            end else if (sts.append_fail) begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = ffsa_pkg::ST_NOSPACE;
                                state_next     = S_RESP;
                            end else begin
                                state_next = S_APPEND;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = S_REM;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            S_REM: begin
                cmd.wr_rem = 1'b1;
                state_next = S_TAKE;
            end
            S_TAKE: begin
                cmd.wr_take  = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_kind = ffsa_pkg::RES_HIT_ID_ADDR;
                state_next   = S_RESP;
            end
            S_APPEND: begin
                cmd.wr_append = 1'b1;
                cmd.res_set   = 1'b1;
                cmd.res_kind  = ffsa_pkg::RES_APPEND;
                state_next    = S_RESP;
            end
            S_COMPACT: begin
                if (sts.compact_done) begin
                    state_next = S_FLUSH;
                end else begin
                    cmd.compact = 1'b1;
                end
            end
            S_FLUSH: begin
                cmd.flush   = 1'b1;
                cmd.res_set = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/first_fit_segment_allocator_unit.sv
// channel   | dir | handshake                  | payload
// s_        | in  | s_tvalid / s_tready        | s_tdata: op, size_bytes, seg_id, requester
// m_        | out | m_tvalid / m_tready        | m_tdata: status, result_id, address
// cfg_      | in  | cfg_valid / cfg_ready      | cfg_data: base_page
//
// one request at a time; the table scan reads the live entries, one memory read per
// cycle, up to the first match, then one write or decision step and the result load;
// a split adds the shift of the entries above the hit and the remainder write, a free
// adds a merge pass, and a free-all does the merge pass in place of the scan.
// reset (aresetn low, synchronous) empties the table, zeroes the id counter and
// sets base and tail to page 131072. a result waits in the output register while
// m_tready is low; the next request is taken once the previous result is loaded there.
module first_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = 64,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // op[1:0], size_bytes[33:2], seg_id[65:34], requester[81:66]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // status[1:0], result_id[33:2], address[65:34]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);

    ffsa_pkg::cmd_t cmd;
    ffsa_pkg::sts_t sts;
    logic [1:0]     out_status;
    logic [31:0]    out_id;
    logic [31:0]    out_addr;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {6'd0, out_addr, out_id, out_status};

    // request sequencer
    ffsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // segment table and arithmetic
    ffsa_dpath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tdata[1:0]),
        .in_size    (s_tdata[33:2]),
        .in_id      (s_tdata[65:34]),
        .in_req     (s_tdata[81:66]),
        .cfg_we     (cfg_valid),
        .cfg_base   (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_id     (out_id),
        .out_addr   (out_addr)
    );

endmodule
